[rtl/core/aar3d_pkg.sv]
// types, constants and fixed-point helpers for the axis-angle rotation block
package aar3d_pkg;

	localparam int FRAC_BITS = 16;

	localparam int COORD_W = 32;
	localparam int BZ_W    = COORD_W + 1;
	localparam int AXIS_W  = 18;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 3;
	localparam int ACC_W   = 64;

	localparam int W_W   = (FRAC_BITS + 2 > AXIS_W + 1) ? FRAC_BITS + 2 : AXIS_W + 1;
	localparam int WP_W  = W_W + AXIS_W;
	localparam int WU_W  = FRAC_BITS + 4;
	localparam int EB_W  = 37;
	localparam int PB_W  = AXIS_W + BZ_W;
	localparam int ME_W  = WU_W + EB_W;
	localparam int MC_W  = AXIS_W + EB_W;
	localparam int R_W   = ACC_W - FRAC_BITS;

	localparam logic signed [ACC_W-1:0] ONE_ACC  = ACC_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] WU_LIM   = ACC_W'(64'sd1 <<< (FRAC_BITS + 2));
	localparam logic signed [ACC_W-1:0] EB_LIM   = ACC_W'(64'sd1 <<< 35);
	localparam logic signed [ACC_W-1:0] C_MAX    = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] C_MIN    = -ACC_W'(64'sd2147483648);

	localparam logic signed [AXIS_W-1:0] AXIS_ONE = AXIS_W'(65536);

	typedef enum logic [IDX_W-1:0] {
		REG_AXIS_X    = 3'd0,
		REG_AXIS_Y    = 3'd1,
		REG_AXIS_Z    = 3'd2,
		REG_COS_ANGLE = 3'd3,
		REG_SIN_ANGLE = 3'd4,
		REG_PIVOT_Z   = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} pos_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] new_x;
		logic signed [COORD_W-1:0] new_y;
		logic signed [COORD_W-1:0] new_z;
	} rot_word_t;

	// round half up, then drop the fraction
	function automatic logic signed [ACC_W-1:0] rnd_acc(input logic signed [ACC_W-1:0] v);
		return (v + HALF_ACC) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [ACC_W-1:0] v,
		input logic signed [ACC_W-1:0] lim);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > lim) r = lim;
		if (v < -lim) r = -lim;
		return r;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		r = v;
		if (v > C_MAX) r = C_MAX;
		if (v < C_MIN) r = C_MIN;
		return r[COORD_W-1:0];
	endfunction

endpackage

[rtl/core/axis_angle_rotation_3d.sv]
// axis-angle (rodrigues) rotation of particle positions, six-stage pipeline
//
// Rotates each position word about the axis (axis_x, axis_y, axis_z) by the angle given
// as cos_angle and sin_angle, all Q1.16; z is taken relative to pivot_z and pivot_z is
// added back. Coordinates are Q16.16 and each result saturates to 32 bits. The pipeline
// takes one word per cycle unless stalled; each word passes through stages s1 to s6
// before its result is offered. The depth is set by the two multiplier ranks (dot and
// cross products, then the weighted sum), each followed by a rounding stage. A stall on
// the output lets words close up into empty stages before the input is stalled. The
// (1 - cos) * axis weights are rebuilt from the registers through w_q, wp*_q and wu*_q
// after a write, which stays ahead of any word accepted after that write.
module axis_angle_rotation_3d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [aar3d_pkg::IDX_W-1:0]   cfg_index,
	input  logic [aar3d_pkg::CFG_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  aar3d_pkg::pos_word_t          in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output aar3d_pkg::rot_word_t          out_data
);
	import aar3d_pkg::*;

	// configuration registers
	logic signed [AXIS_W-1:0]  axis_x_q, axis_y_q, axis_z_q, cos_q, sin_q;
	logic signed [COORD_W-1:0] pivot_q;

	// derived weights
	logic signed [W_W-1:0]  w_q;
	logic signed [WP_W-1:0] wpx_q, wpy_q, wpz_q;
	logic signed [WU_W-1:0] wux_q, wuy_q, wuz_q;

	// pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic signed [COORD_W-1:0] bx_s1, by_s1, bx_s2, by_s2, bx_s3, by_s3;
	logic signed [BZ_W-1:0]    bz_s1, bz_s2, bz_s3;

	logic signed [PB_W-1:0] pex_s2, pey_s2, pez_s2;
	logic signed [PB_W-1:0] qyz_s2, qzy_s2, qzx_s2, qxz_s2, qxy_s2, qyx_s2;

	logic signed [EB_W-1:0] eb_s3, cx_s3, cy_s3, cz_s3;

	logic signed [ME_W-1:0] mex_s4, mey_s4, mez_s4;
	logic signed [PB_W-1:0] mcx_s4, mcy_s4, mcz_s4;
	logic signed [MC_W-1:0] msx_s4, msy_s4, msz_s4;

	logic signed [R_W-1:0] rx_s5, ry_s5, rz_s5;

	rot_word_t out_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q <= '0;
			axis_y_q <= '0;
			axis_z_q <= AXIS_ONE;
			cos_q    <= AXIS_ONE;
			sin_q    <= '0;
			pivot_q  <= '0;
		end else if (cfg_wen) begin
			unique case (reg_index_t'(cfg_index))
				REG_AXIS_X:    axis_x_q <= $signed(cfg_data[AXIS_W-1:0]);
				REG_AXIS_Y:    axis_y_q <= $signed(cfg_data[AXIS_W-1:0]);
				REG_AXIS_Z:    axis_z_q <= $signed(cfg_data[AXIS_W-1:0]);
				REG_COS_ANGLE: cos_q    <= $signed(cfg_data[AXIS_W-1:0]);
				REG_SIN_ANGLE: sin_q    <= $signed(cfg_data[AXIS_W-1:0]);
				REG_PIVOT_Z:   pivot_q  <= $signed(cfg_data[COORD_W-1:0]);
				default: ;
			endcase
		end
	end

	// (1 - cos) * axis, rounded and clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= '0;
			wpx_q <= '0;
			wpy_q <= '0;
			wpz_q <= '0;
			wux_q <= '0;
			wuy_q <= '0;
			wuz_q <= '0;
		end else begin
			w_q   <= W_W'(ONE_ACC - ACC_W'(cos_q));
			wpx_q <= w_q * axis_x_q;
			wpy_q <= w_q * axis_y_q;
			wpz_q <= w_q * axis_z_q;
			wux_q <= WU_W'(clamp_acc(rnd_acc(ACC_W'(wpx_q)), WU_LIM));
			wuy_q <= WU_W'(clamp_acc(rnd_acc(ACC_W'(wpy_q)), WU_LIM));
			wuz_q <= WU_W'(clamp_acc(rnd_acc(ACC_W'(wpz_q)), WU_LIM));
		end
	end

	// a stage loads when it is empty or the next one moves
	assign en6 = !v_s6 || !out_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_stall  = !en1;
	assign out_valid = v_s6;
	assign out_data  = out_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// input word, z relative to pivot
	always_ff @(posedge clk) begin
		if (en1) begin
			bx_s1 <= in_data.pos_x;
			by_s1 <= in_data.pos_y;
			bz_s1 <= BZ_W'(in_data.pos_z) - BZ_W'(pivot_q);
		end
	end

	// dot and cross products
	always_ff @(posedge clk) begin
		if (en2) begin
			pex_s2 <= axis_x_q * BZ_W'(bx_s1);
			pey_s2 <= axis_y_q * BZ_W'(by_s1);
			pez_s2 <= axis_z_q * bz_s1;
			qyz_s2 <= axis_y_q * bz_s1;
			qzy_s2 <= axis_z_q * BZ_W'(by_s1);
			qzx_s2 <= axis_z_q * BZ_W'(bx_s1);
			qxz_s2 <= axis_x_q * bz_s1;
			qxy_s2 <= axis_x_q * BZ_W'(by_s1);
			qyx_s2 <= axis_y_q * BZ_W'(bx_s1);
			bx_s2  <= bx_s1;
			by_s2  <= by_s1;
			bz_s2  <= bz_s1;
		end
	end

	// sums, rounding and guard clamp
	always_ff @(posedge clk) begin
		if (en3) begin
			eb_s3 <= EB_W'(clamp_acc(rnd_acc(ACC_W'(pex_s2) + ACC_W'(pey_s2) + ACC_W'(pez_s2)),
				EB_LIM));
			cx_s3 <= EB_W'(clamp_acc(rnd_acc(ACC_W'(qyz_s2) - ACC_W'(qzy_s2)), EB_LIM));
			cy_s3 <= EB_W'(clamp_acc(rnd_acc(ACC_W'(qzx_s2) - ACC_W'(qxz_s2)), EB_LIM));
			cz_s3 <= EB_W'(clamp_acc(rnd_acc(ACC_W'(qxy_s2) - ACC_W'(qyx_s2)), EB_LIM));
			bx_s3 <= bx_s2;
			by_s3 <= by_s2;
			bz_s3 <= bz_s2;
		end
	end

	// weighted terms
	always_ff @(posedge clk) begin
		if (en4) begin
			mex_s4 <= ME_W'(wux_q) * ME_W'(eb_s3);
			mey_s4 <= ME_W'(wuy_q) * ME_W'(eb_s3);
			mez_s4 <= ME_W'(wuz_q) * ME_W'(eb_s3);
			mcx_s4 <= cos_q * BZ_W'(bx_s3);
			mcy_s4 <= cos_q * BZ_W'(by_s3);
			mcz_s4 <= cos_q * bz_s3;
			msx_s4 <= sin_q * cx_s3;
			msy_s4 <= sin_q * cy_s3;
			msz_s4 <= sin_q * cz_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			rx_s5 <= R_W'(rnd_acc(ACC_W'(mex_s4) + ACC_W'(mcx_s4) + ACC_W'(msx_s4)));
			ry_s5 <= R_W'(rnd_acc(ACC_W'(mey_s4) + ACC_W'(mcy_s4) + ACC_W'(msy_s4)));
			rz_s5 <= R_W'(rnd_acc(ACC_W'(mez_s4) + ACC_W'(mcz_s4) + ACC_W'(msz_s4)));
		end
	end

	// pivot back on z, saturate
	always_ff @(posedge clk) begin
		if (en6) begin
			out_s6.new_x <= sat_coord(ACC_W'(rx_s5));
			out_s6.new_y <= sat_coord(ACC_W'(ry_s5));
			out_s6.new_z <= sat_coord(ACC_W'(rz_s5) + ACC_W'(pivot_q));
		end
	end

endmodule
